// ===== rtl/crtc_pkg.sv =====
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types, register indexes and constants of the cartridge RTC block.
// ----------------------------------------------------------------------------
package crtc_pkg;

    // Request kinds carried by s_req_type.
    typedef enum logic [1:0] {
        REQ_LATCH = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Latched bank register indexes.
    localparam logic [2:0] REG_SEC   = 3'd0;
    localparam logic [2:0] REG_MIN   = 3'd1;
    localparam logic [2:0] REG_HOUR  = 3'd2;
    localparam logic [2:0] REG_DAYLO = 3'd3;
    localparam logic [2:0] REG_FLAGS = 3'd4;

    // Bit positions inside the flag register.
    localparam int FLAG_DAY_HI = 0;
    localparam int FLAG_HALT   = 6;
    localparam int FLAG_CARRY  = 7;

    // Select bit that enables register writes.
    localparam int SEL_WE_BIT = 3;

    localparam int          NUM_REGS     = 8;
    localparam logic [6:0]  TICKS_PER_S  = 7'd60;
    localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
    localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
    localparam logic [5:0]  HOUR_PER_DAY = 6'd24;
    localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
    localparam logic [7:0]  FILL_BYTE    = 8'hFF;

    // One input beat.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data;
        logic [3:0] sel;
    } item_t;

    // Live clock values, exported for checking.
    typedef struct packed {
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic [5:0] subsecond;
    } live_t;

    // Byte reduced modulo 60 by three compare and subtract steps.
    function automatic logic [7:0] mod60(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (v >= 8'd240) v = v - 8'd240;
        if (v >= 8'd120) v = v - 8'd120;
        if (v >= 8'd60)  v = v - 8'd60;
        return v;
    endfunction

    // Byte reduced modulo 24 by four compare and subtract steps.
    function automatic logic [7:0] mod24(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (v >= 8'd192) v = v - 8'd192;
        if (v >= 8'd96)  v = v - 8'd96;
        if (v >= 8'd48)  v = v - 8'd48;
        if (v >= 8'd24)  v = v - 8'd24;
        return v;
    endfunction

endpackage

// ===== rtl/crtc_in_stage.sv =====
// ----------------------------------------------------------------------------
// crtc_in_stage
// Input register of the RTC block; holds one accepted beat until processed.
// ----------------------------------------------------------------------------
module crtc_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  crtc_pkg::item_t s_item,
    input  logic           advance,
    output logic           in_valid,
    output crtc_pkg::item_t in_item
);

    logic            valid_reg;
    logic            valid_next;
    crtc_pkg::item_t item_reg;

    // The register frees up in the same cycle its beat moves on.
    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    // Occupancy of the input register.
    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/crtc_core.sv =====
// ----------------------------------------------------------------------------
// crtc_core
// Live clock, latch edge detector and latched bank; one step per beat.
// ----------------------------------------------------------------------------
module crtc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  crtc_pkg::item_t item,
    output logic [7:0]      rd_next,
    output crtc_pkg::live_t live
);

    logic [5:0] sub_reg,  sub_next;
    logic [5:0] sec_reg,  sec_next;
    logic [5:0] min_reg,  min_next;
    logic [4:0] hour_reg, hour_next;
    logic [8:0] day_reg,  day_next;
    logic       halt_reg, halt_next;
    logic       carry_reg, carry_next;
    logic       last_reg, last_next;
    logic [7:0] bank_reg  [crtc_pkg::NUM_REGS];
    logic [7:0] bank_next [crtc_pkg::NUM_REGS];

    logic [6:0] sub_inc;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [8:0] day_inc;
    logic [7:0] flags_now;
    logic [7:0] data_mod60;
    logic [7:0] data_mod24;
    logic       we;

    assign sub_inc  = {1'b0, sub_reg} + 7'd1;
    assign sec_inc  = {1'b0, sec_reg} + 7'd1;
    assign min_inc  = {1'b0, min_reg} + 7'd1;
    assign hour_inc = {1'b0, hour_reg} + 6'd1;
    assign day_inc  = day_reg + 9'd1;
    assign we       = item.sel[crtc_pkg::SEL_WE_BIT];

    // Written byte reduced to the live clock ranges.
    assign data_mod60 = crtc_pkg::mod60(item.data);
    assign data_mod24 = crtc_pkg::mod24(item.data);

    // Flag byte as a latch captures it.
    always_comb begin
        flags_now                        = 8'h00;
        flags_now[crtc_pkg::FLAG_DAY_HI] = day_reg[8];
        flags_now[crtc_pkg::FLAG_HALT]   = halt_reg;
        flags_now[crtc_pkg::FLAG_CARRY]  = carry_reg;
    end

    // Next state for one beat.
    always_comb begin
        sub_next   = sub_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        halt_next  = halt_reg;
        carry_next = carry_reg;
        last_next  = last_reg;
        bank_next  = bank_reg;

        case (crtc_pkg::req_t'(item.req_type))
            crtc_pkg::REQ_LATCH: begin
                // Copy the live clock on a rising edge of data bit 0.
                if (item.data[0] && !last_reg) begin
                    bank_next[crtc_pkg::REG_SEC]   = {2'b00, sec_reg};
                    bank_next[crtc_pkg::REG_MIN]   = {2'b00, min_reg};
                    bank_next[crtc_pkg::REG_HOUR]  = {3'b000, hour_reg};
                    bank_next[crtc_pkg::REG_DAYLO] = day_reg[7:0];
                    bank_next[crtc_pkg::REG_FLAGS] = flags_now;
                    for (int i = int'(crtc_pkg::REG_FLAGS) + 1; i < crtc_pkg::NUM_REGS;
                         i++) begin
                        bank_next[i] = crtc_pkg::FILL_BYTE;
                    end
                end
                last_next = item.data[0];
            end
            crtc_pkg::REQ_WRITE: begin
                // Writes update the latched byte as is and the live clock reduced.
                if (we) begin
                    case (item.sel[2:0])
                        crtc_pkg::REG_SEC: begin
                            bank_next[crtc_pkg::REG_SEC] = item.data;
                            sec_next = data_mod60[5:0];
                        end
                        crtc_pkg::REG_MIN: begin
                            bank_next[crtc_pkg::REG_MIN] = item.data;
                            min_next = data_mod60[5:0];
                        end
                        crtc_pkg::REG_HOUR: begin
                            bank_next[crtc_pkg::REG_HOUR] = item.data;
                            hour_next = data_mod24[4:0];
                        end
                        crtc_pkg::REG_DAYLO: begin
                            bank_next[crtc_pkg::REG_DAYLO] = item.data;
                            day_next = {day_reg[8], item.data};
                        end
                        crtc_pkg::REG_FLAGS: begin
                            bank_next[crtc_pkg::REG_FLAGS] = item.data;
                            day_next   = {item.data[crtc_pkg::FLAG_DAY_HI], day_reg[7:0]};
                            halt_next  = item.data[crtc_pkg::FLAG_HALT];
                            carry_next = item.data[crtc_pkg::FLAG_CARRY];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            crtc_pkg::REQ_TICK: begin
                // Carry cascade from subsecond up to the day counter.
                if (!halt_reg) begin
                    if (sub_inc < crtc_pkg::TICKS_PER_S) begin
                        sub_next = sub_inc[5:0];
                    end else begin
                        sub_next = 6'd0;
                        if (sec_inc < crtc_pkg::SEC_PER_MIN) begin
                            sec_next = sec_inc[5:0];
                        end else begin
                            sec_next = 6'd0;
                            if (min_inc < crtc_pkg::MIN_PER_HOUR) begin
                                min_next = min_inc[5:0];
                            end else begin
                                min_next = 6'd0;
                                if (hour_inc < crtc_pkg::HOUR_PER_DAY) begin
                                    hour_next = hour_inc[4:0];
                                end else begin
                                    hour_next = 5'd0;
                                    if (day_inc == crtc_pkg::DAYS_PER_YR) begin
                                        day_next   = 9'd0;
                                        carry_next = 1'b1;
                                    end else begin
                                        day_next = day_inc;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The result reads the bank as it stands after the step.
    assign rd_next = bank_next[item.sel[2:0]];

    assign live.seconds   = sec_reg;
    assign live.minutes   = min_reg;
    assign live.hours     = hour_reg;
    assign live.subsecond = sub_reg;

    // State registers, updated once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= 6'd0;
            sec_reg   <= 6'd0;
            min_reg   <= 6'd0;
            hour_reg  <= 5'd0;
            day_reg   <= 9'd0;
            halt_reg  <= 1'b0;
            carry_reg <= 1'b0;
            last_reg  <= 1'b0;
            for (int i = 0; i < crtc_pkg::NUM_REGS; i++) begin
                bank_reg[i] <= 8'h00;
            end
        end else if (advance) begin
            sub_reg   <= sub_next;
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            halt_reg  <= halt_next;
            carry_reg <= carry_next;
            last_reg  <= last_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== rtl/crtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// crtc_out_stage
// Result register of the RTC block; holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module crtc_out_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  logic [7:0] load_data,
    output logic       can_load,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign can_load    = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_read_data = data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/cartridge_rtc_latch_write_tick_top.sv =====
// ----------------------------------------------------------------------------
// cartridge_rtc_latch_write_tick_top
// Cartridge real-time clock with latch, register write and 60 Hz tick.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_req_type, s_data, s_sel) carries one
// request per beat: a latch control byte, a register write or one tick. The
// result channel (m_valid, m_ready, m_read_data) returns one beat per request,
// the latched register picked by the low three select bits after the request.
// A beat goes through an input register, one pass of clock logic and a result
// register, and m_valid rises once the result register has loaded the beat.
// One beat is accepted every cycle while the receiver takes results; the clock
// state steps once per beat. When the receiver stalls, the result register holds its
// beat and the input register holds one more; s_ready then falls until the
// receiver takes the held result. Reset clears the live clock, the flags, the
// latch edge detector and the latched bank to zero and empties both registers.
// ----------------------------------------------------------------------------
module cartridge_rtc_latch_write_tick_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_data,
    input  logic [3:0] s_sel,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data
);

    crtc_pkg::item_t s_item;
    crtc_pkg::item_t in_item;
    crtc_pkg::live_t live;
    logic            in_valid;
    logic            can_load;
    logic            advance;
    logic [7:0]      rd_next;

    assign s_item.req_type = s_req_type;
    assign s_item.data     = s_data;
    assign s_item.sel      = s_sel;

    // A held request is processed once the result register has room.
    assign advance = in_valid && can_load;

    crtc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    crtc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item),
        .rd_next (rd_next),
        .live    (live)
    );

    crtc_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_data   (rd_next),
        .can_load    (can_load),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

    // A processed request always produces a result beat in the next cycle.
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed request produced no result beat");

    // With both registers full and the receiver stalled, no beat is taken.
    a_full_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline is full and stalled");

    // Reset empties both registers.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid))
        else $error("registers not empty after reset");

    // The live clock never leaves its counting ranges.
    a_live_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (live.seconds < 6'd60) && (live.minutes < 6'd60) && (live.hours < 5'd24)
        && (live.subsecond < 6'd60))
        else $error("live clock value out of range");

endmodule
